@@ rtl/sawt_pkg.sv @@
package sawt_pkg;

  localparam int SEQ_W  = 16;
  localparam int MASK_W = 32;
  localparam int STAT_W = 3;

  localparam logic [1:0] ACT_RX   = 2'd0;
  localparam logic [1:0] ACT_DLV  = 2'd1;
  localparam logic [1:0] ACT_SEND = 2'd2;
  localparam logic [1:0] ACT_POLL = 2'd3;

  localparam logic [STAT_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STAT_W-1:0] ST_OUTSIDE = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP     = 3'd2;
  localparam logic [STAT_W-1:0] ST_SHORT   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTHING = 3'd4;

  localparam logic [SEQ_W-1:0] SEQ_LAST = 16'hffff;
  localparam logic [SEQ_W-1:0] HALF     = 16'h8000;

  typedef struct packed {
    logic rx;
    logic dlv;
    logic snd;
    logic poll;
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [SEQ_W-1:0]   rx_seq;
    logic [SEQ_W-1:0]   peer_ack_next;
    logic [MASK_W-1:0]  peer_ack_mask;
    logic               payload_fits;
  } entry_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SEQ_W-1:0]   seq_out;
    logic               transmitted;
    logic [SEQ_W-1:0]   report_next;
    logic [MASK_W-1:0]  report_mask;
  } result_t;

endpackage

@@ rtl/selective_ack_window_tracker_top.sv @@
// Sequence scoreboard of a reliable datagram link, one event per beat; every event gives
// exactly one result beat. Events queue in a two-entry front queue and are carried out one
// at a time by a sequencer that walks the slot memories one slot per cycle. Receive: an
// accepted packet scans all WINDOW_SLOTS slots, then walks min(REPORT_BITS,32) mask bits;
// a rejected one ends at the check. Deliver: one slot read. Send: walks the run of
// in-order received packets from the next expected one (at most WINDOW_SLOTS), then the
// mask bits. Resend poll: scans all slots, then the send walks if a packet goes out.
// resend_age may be written only while the block is idle.
module selective_ack_window_tracker_top #(
  parameter int WINDOW_SLOTS = 64,
  parameter int REPORT_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   action,
  input  logic [sawt_pkg::SEQ_W-1:0]   rx_seq,
  input  logic [sawt_pkg::SEQ_W-1:0]   peer_ack_next,
  input  logic [sawt_pkg::MASK_W-1:0]  peer_ack_mask,
  input  logic                         payload_fits,
  output logic                         empty,
  input  logic                         pop,
  output logic [sawt_pkg::STAT_W-1:0]  status,
  output logic [sawt_pkg::SEQ_W-1:0]   seq_out,
  output logic                         transmitted,
  output logic [sawt_pkg::SEQ_W-1:0]   report_next,
  output logic [sawt_pkg::MASK_W-1:0]  report_mask,
  input  logic                         cfg_we,
  input  logic [14:0]                  cfg_data
);

  logic              ev_valid;
  logic              ev_pop;
  sawt_pkg::entry_t  ev;
  logic              done;
  sawt_pkg::result_t res;
  sawt_pkg::result_t out_reg;
  logic              out_full;
  logic [14:0]       resend_age;

  sawt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .action        (action),
    .rx_seq        (rx_seq),
    .peer_ack_next (peer_ack_next),
    .peer_ack_mask (peer_ack_mask),
    .payload_fits  (payload_fits),
    .ev_valid      (ev_valid),
    .ev            (ev),
    .ev_pop        (ev_pop)
  );

  sawt_back #(
    .WINDOW_SLOTS (WINDOW_SLOTS),
    .REPORT_BITS  (REPORT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .ev_valid   (ev_valid),
    .ev         (ev),
    .ev_pop     (ev_pop),
    .resend_age (resend_age),
    .out_full   (out_full),
    .done       (done),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      resend_age <= 15'd32;
      out_full   <= 1'b0;
    end else begin
      if (cfg_we) begin
        resend_age <= cfg_data;
      end
      if (done) begin
        out_full <= 1'b1;
      end else if (pop && out_full) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_reg <= res;
    end
  end

  assign empty       = !out_full;
  assign status      = out_reg.status;
  assign seq_out     = out_reg.seq_out;
  assign transmitted = out_reg.transmitted;
  assign report_next = out_reg.report_next;
  assign report_mask = out_reg.report_mask;

endmodule

@@ rtl/sawt_front.sv @@
module sawt_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     action,
  input  logic [sawt_pkg::SEQ_W-1:0]     rx_seq,
  input  logic [sawt_pkg::SEQ_W-1:0]     peer_ack_next,
  input  logic [sawt_pkg::MASK_W-1:0]    peer_ack_mask,
  input  logic                           payload_fits,
  output logic                           ev_valid,
  output sawt_pkg::entry_t               ev,
  input  logic                           ev_pop
);

  sawt_pkg::entry_t q [2];
  sawt_pkg::entry_t in_entry;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    in_entry               = '0;
    in_entry.kind.rx       = (action == sawt_pkg::ACT_RX);
    in_entry.kind.dlv      = (action == sawt_pkg::ACT_DLV);
    in_entry.kind.snd      = (action == sawt_pkg::ACT_SEND);
    in_entry.kind.poll     = (action == sawt_pkg::ACT_POLL);
    in_entry.rx_seq        = rx_seq;
    in_entry.peer_ack_next = peer_ack_next;
    in_entry.peer_ack_mask = peer_ack_mask;
    in_entry.payload_fits  = payload_fits;
  end

  assign full     = (cnt == 2'd2);
  assign ev_valid = (cnt != 2'd0);
  assign ev       = q[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = ev_pop && ev_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

@@ rtl/sawt_back.sv @@
module sawt_back #(
  parameter int WINDOW_SLOTS = 64,
  parameter int REPORT_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         ev_valid,
  input  sawt_pkg::entry_t             ev,
  output logic                         ev_pop,
  input  logic [14:0]                  resend_age,
  input  logic                         out_full,
  output logic                         done,
  output sawt_pkg::result_t            res
);

  localparam int SW = $clog2(WINDOW_SLOTS);
  localparam int NW = $clog2(WINDOW_SLOTS + 1);
  localparam int KR = (REPORT_BITS < 32) ? REPORT_BITS : 32;
  localparam int KW = $clog2(KR);
  localparam logic [SW-1:0] LAST  = SW'(WINDOW_SLOTS - 1);
  localparam logic [NW-1:0] NLAST = NW'(WINDOW_SLOTS - 1);
  localparam logic [KW-1:0] KLAST = KW'(KR - 1);
  localparam logic [15:0]   WIN   = 16'(WINDOW_SLOTS);
  localparam logic [16:0]   WIN17 = 17'(WINDOW_SLOTS);
  localparam logic [32:0]   RECIP =
    33'(((64'd1 << 32) + 64'(WINDOW_SLOTS) - 64'd1) / 64'(WINDOW_SLOTS));

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MODA  = 4'd1;
  localparam logic [3:0] S_MODB  = 4'd2;
  localparam logic [3:0] S_RXCHK = 4'd3;
  localparam logic [3:0] S_ACK1  = 4'd4;
  localparam logic [3:0] S_ACK2  = 4'd5;
  localparam logic [3:0] S_DLV   = 4'd6;
  localparam logic [3:0] S_RS    = 4'd7;
  localparam logic [3:0] S_RS2   = 4'd8;
  localparam logic [3:0] S_TX    = 4'd9;
  localparam logic [3:0] S_RUN   = 4'd10;
  localparam logic [3:0] S_MSK0  = 4'd11;
  localparam logic [3:0] S_MSK   = 4'd12;

  function automatic logic [SW-1:0] inc_slot(input logic [SW-1:0] s, input logic [15:0] sq);
    inc_slot = (sq == sawt_pkg::SEQ_LAST || s == LAST) ? '0 : s + SW'(1);
  endfunction

  logic [3:0]    state;
  sawt_pkg::entry_t it;
  logic [SW-1:0] ptr;
  logic [SW-1:0] ptr_next;
  logic [15:0]   ne;
  logic [SW-1:0] ne_slot;
  logic [15:0]   ns;
  logic [SW-1:0] ns_slot;
  logic [15:0]   try_cnt;
  logic [WINDOW_SLOTS-1:0] rv;
  logic [WINDOW_SLOTS-1:0] tv;
  logic [WINDOW_SLOTS-1:0] dl;
  logic [15:0]   rx_mem  [WINDOW_SLOTS];
  logic [15:0]   txs_mem [WINDOW_SLOTS];
  logic [15:0]   try_mem [WINDOW_SLOTS];
  logic [15:0]   rd_rx;
  logic [15:0]   rd_txs;
  logic [15:0]   rd_try;
  logic [15:0]   modx;
  logic [15:0]   quo;
  logic          mod_mask;
  logic [15:0]   cur_seq;
  logic [KW-1:0] k;
  logic [NW-1:0] n;
  logic          found;
  logic [SW-1:0] best;
  logic [15:0]   best_try;
  logic [SW-1:0] tx_i;
  logic [15:0]   out_seq;
  logic [15:0]   rep_next;
  logic [31:0]   rep_mask;

  logic          start;
  logic [48:0]   prod;
  logic [SW-1:0] rem;
  logic [15:0]   win_d;
  logic          outside;
  logic          dup;
  logic [15:0]   ack_d;
  logic          ack_hit;
  logic          mask_hit;
  logic          better;
  logic          cand;
  logic          wfull;
  logic [15:0]   age;
  logic          go;
  logic          hold;
  logic          dlv_hold;
  logic [31:0]   mask_now;

  assign start    = (state == S_IDLE) && ev_valid && !out_full;
  assign ev_pop   = start;
  assign prod     = 49'(modx) * 49'(RECIP);
  assign rem      = SW'(modx - 16'(32'(quo) * 32'(WINDOW_SLOTS)));
  assign win_d    = it.rx_seq - ne;
  assign outside  = (win_d >= WIN);
  assign dup      = rv[ptr] && (rd_rx == it.rx_seq);
  assign ack_d    = it.peer_ack_next - rd_txs;
  assign ack_hit  = tv[ptr] && (ack_d != 16'd0) && ({1'b0, ack_d} <= WIN17);
  assign mask_hit = it.peer_ack_mask[k] && tv[ptr] && (rd_txs == cur_seq);
  assign cand     = tv[ptr] && !dl[ptr];
  assign better   = !found || !(16'(best_try - rd_try) >= sawt_pkg::HALF);
  assign wfull    = tv[ns_slot] && !dl[ns_slot] && (rd_txs == ns - WIN);
  assign age      = try_cnt - best_try;
  assign go       = found && ((age >= {1'b0, resend_age}) || wfull);
  assign hold     = rv[ptr] && (rd_rx == cur_seq);
  assign dlv_hold = rv[ptr] && (rd_rx == ne);
  assign mask_now = rep_mask | (32'(hold) << k);

  always_comb begin
    ptr_next = ptr;
    case (state)
      S_IDLE: begin
        if (start && ev.kind.dlv) begin
          ptr_next = ne_slot;
        end else if (start && ev.kind.poll) begin
          ptr_next = '0;
        end
      end
      S_MODB:  ptr_next = rem;
      S_RXCHK: begin
        if (!outside && !dup && it.payload_fits) begin
          ptr_next = '0;
        end
      end
      S_ACK1: begin
        if (ptr != LAST) begin
          ptr_next = ptr + SW'(1);
        end
      end
      S_ACK2:  ptr_next = inc_slot(ptr, cur_seq);
      S_RS:    ptr_next = (ptr == LAST) ? ns_slot : ptr + SW'(1);
      S_RS2:   ptr_next = best;
      S_TX:    ptr_next = ne_slot;
      S_RUN: begin
        if (hold) begin
          ptr_next = inc_slot(ptr, cur_seq);
        end
      end
      S_MSK0:  ptr_next = inc_slot(ptr, cur_seq);
      S_MSK:   ptr_next = inc_slot(ptr, cur_seq);
      default: ptr_next = ptr;
    endcase
  end

  always_comb begin
    done = 1'b0;
    res  = '0;
    case (state)
      S_RXCHK: begin
        if (outside) begin
          done       = 1'b1;
          res.status = sawt_pkg::ST_OUTSIDE;
        end else if (dup) begin
          done       = 1'b1;
          res.status = sawt_pkg::ST_DUP;
        end else if (!it.payload_fits) begin
          done       = 1'b1;
          res.status = sawt_pkg::ST_SHORT;
        end
      end
      S_ACK2: begin
        if (k == KLAST) begin
          done       = 1'b1;
          res.status = sawt_pkg::ST_DONE;
        end
      end
      S_DLV: begin
        done        = 1'b1;
        res.status  = dlv_hold ? sawt_pkg::ST_DONE : sawt_pkg::ST_NOTHING;
        res.seq_out = dlv_hold ? ne : 16'd0;
      end
      S_RS2: begin
        if (!go) begin
          done       = 1'b1;
          res.status = sawt_pkg::ST_NOTHING;
        end
      end
      S_MSK: begin
        if (k == KLAST) begin
          done            = 1'b1;
          res.status      = sawt_pkg::ST_DONE;
          res.seq_out     = out_seq;
          res.transmitted = 1'b1;
          res.report_next = rep_next;
          res.report_mask = mask_now;
        end
      end
      default: done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_rx  <= rx_mem[ptr_next];
    rd_txs <= txs_mem[ptr_next];
    rd_try <= try_mem[ptr_next];
    if (state == S_RXCHK && !outside && !dup && it.payload_fits) begin
      rx_mem[ptr] <= it.rx_seq;
    end
    if (start && ev.kind.snd) begin
      txs_mem[ns_slot] <= ns;
    end
    if (state == S_TX) begin
      try_mem[tx_i] <= try_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ptr      <= '0;
      ne       <= '0;
      ne_slot  <= '0;
      ns       <= '0;
      ns_slot  <= '0;
      try_cnt  <= '0;
      rv       <= '0;
      tv       <= '0;
      dl       <= '0;
      found    <= 1'b0;
      mod_mask <= 1'b0;
    end else begin
      ptr <= ptr_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            it <= ev;
            if (ev.kind.rx) begin
              modx     <= ev.rx_seq;
              mod_mask <= 1'b0;
              state    <= S_MODA;
            end else if (ev.kind.dlv) begin
              state <= S_DLV;
            end else if (ev.kind.snd) begin
              tv[ns_slot] <= 1'b1;
              dl[ns_slot] <= 1'b0;
              out_seq     <= ns;
              tx_i        <= ns_slot;
              ns          <= ns + 16'd1;
              ns_slot     <= inc_slot(ns_slot, ns);
              state       <= S_TX;
            end else begin
              found <= 1'b0;
              state <= S_RS;
            end
          end
        end
        S_MODA: begin
          quo   <= prod[47:32];
          state <= S_MODB;
        end
        S_MODB: begin
          if (mod_mask) begin
            cur_seq <= modx;
            k       <= '0;
            state   <= S_ACK2;
          end else begin
            state <= S_RXCHK;
          end
        end
        S_RXCHK: begin
          if (outside || dup) begin
            state <= S_IDLE;
          end else if (!it.payload_fits) begin
            rv[ptr] <= 1'b0;
            state   <= S_IDLE;
          end else begin
            rv[ptr] <= 1'b1;
            state   <= S_ACK1;
          end
        end
        S_ACK1: begin
          if (ack_hit) begin
            dl[ptr] <= 1'b1;
          end
          if (ptr == LAST) begin
            modx     <= it.peer_ack_next + 16'd1;
            mod_mask <= 1'b1;
            state    <= S_MODA;
          end
        end
        S_ACK2: begin
          if (mask_hit) begin
            dl[ptr] <= 1'b1;
          end
          if (k == KLAST) begin
            state <= S_IDLE;
          end else begin
            k       <= k + KW'(1);
            cur_seq <= cur_seq + 16'd1;
          end
        end
        S_DLV: begin
          if (dlv_hold) begin
            ne      <= ne + 16'd1;
            ne_slot <= inc_slot(ne_slot, ne);
          end
          state <= S_IDLE;
        end
        S_RS: begin
          if (cand && better) begin
            best     <= ptr;
            best_try <= rd_try;
            found    <= 1'b1;
          end
          if (ptr == LAST) begin
            state <= S_RS2;
          end
        end
        S_RS2: begin
          if (go) begin
            tx_i  <= best;
            state <= S_TX;
          end else begin
            state <= S_IDLE;
          end
        end
        S_TX: begin
          try_cnt <= try_cnt + 16'd1;
          if (it.kind.poll) begin
            out_seq <= rd_txs;
          end
          cur_seq  <= ne;
          n        <= '0;
          rep_mask <= '0;
          state    <= S_RUN;
        end
        S_RUN: begin
          if (hold && n != NLAST) begin
            cur_seq <= cur_seq + 16'd1;
            n       <= n + NW'(1);
          end else if (hold) begin
            cur_seq  <= cur_seq + 16'd1;
            rep_next <= cur_seq + 16'd1;
            state    <= S_MSK0;
          end else begin
            rep_next <= cur_seq;
            state    <= S_MSK0;
          end
        end
        S_MSK0: begin
          cur_seq <= cur_seq + 16'd1;
          k       <= '0;
          state   <= S_MSK;
        end
        S_MSK: begin
          rep_mask <= mask_now;
          if (k == KLAST) begin
            state <= S_IDLE;
          end else begin
            k       <= k + KW'(1);
            cur_seq <= cur_seq + 16'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_room: assert property (@(posedge clk) disable iff (rst) done |-> !out_full)
    else $error("result while output stage full");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |=> state == S_IDLE)
    else $error("sequencer not idle after result");
  a_quiet_report: assert property (@(posedge clk) disable iff (rst)
    done && !res.transmitted |-> res.report_next == 16'd0 && res.report_mask == 32'd0)
    else $error("report fields set without transmission");
  a_try_step: assert property (@(posedge clk) disable iff (rst)
    state == S_TX |=> try_cnt == $past(try_cnt) + 16'd1)
    else $error("try counter did not advance on transmit");

endmodule
